// File: src/cor_pkg.sv
// Shared types and constants for the circle octant rasterizer.
package cor_pkg;

  localparam int unsigned CoordW  = 14;
  localparam int unsigned StepW   = 13;
  localparam int unsigned DecW    = 17;
  localparam int unsigned RadW    = 12;
  localparam int unsigned OffW    = 12;
  localparam int unsigned PointW  = 15;
  localparam int unsigned ArithW  = 16;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [IdxW-1:0]  LastIdx     = 3'd7;
  localparam logic             RegFoldOff  = 1'b0;
  localparam logic [OffW-1:0]  FoldOffRst  = 12'd180;
  localparam logic             ModeStart   = 1'b0;

  // Center and octant position held for the eight points of one step.
  typedef struct packed {
    logic signed [CoordW-1:0] h;
    logic signed [CoordW-1:0] k;
    logic        [StepW-1:0]  x;
    logic signed [StepW-1:0]  y;
    logic                     done;
  } step_snap_t;

endpackage

// File: src/cor_point_gen.sv
// Combinational generator of one symmetric point of a rasterizer step.
module cor_point_gen import cor_pkg::*; (
  input  step_snap_t               snap_i,
  input  logic [IdxW-1:0]          idx_i,
  input  logic [OffW-1:0]          offset_i,
  output logic signed [PointW-1:0] point_x_o,
  output logic signed [PointW-1:0] point_y_o
);

  logic signed [ArithW-1:0] h_ext;
  logic signed [ArithW-1:0] k_ext;
  logic signed [ArithW-1:0] x_ext;
  logic signed [ArithW-1:0] y_ext;
  logic signed [ArithW-1:0] o_ext;
  logic signed [ArithW-1:0] u_val;
  logic signed [ArithW-1:0] v_val;
  logic signed [ArithW-1:0] px;
  logic signed [ArithW-1:0] py;

  always_comb begin
    h_ext = {{(ArithW-CoordW){snap_i.h[CoordW-1]}}, snap_i.h};
    k_ext = {{(ArithW-CoordW){snap_i.k[CoordW-1]}}, snap_i.k};
    x_ext = {{(ArithW-StepW){1'b0}}, snap_i.x};
    y_ext = {{(ArithW-StepW){snap_i.y[StepW-1]}}, snap_i.y};
    o_ext = {{(ArithW-OffW){1'b0}}, offset_i};
    // The upper four points swap the roles of x and y.
    u_val = idx_i[2] ? y_ext : x_ext;
    v_val = idx_i[2] ? x_ext : y_ext;
    px    = idx_i[0] ? (h_ext - u_val + o_ext) : (h_ext + u_val);
    py    = idx_i[1] ? (k_ext - v_val) : (k_ext + v_val - o_ext);
  end

  assign point_x_o = px[PointW-1:0];
  assign point_y_o = py[PointW-1:0];

endmodule

// File: src/circle_octant_rasterizer.sv
// Top level of the octant-symmetric circle rasterizer with fold offset.
//
// Input beats carry mode, center and radius. A start beat (mode 0) loads the
// center and radius and produces no output. A step beat (mode 1) of a circle
// in progress produces eight point beats on the output channel, one per cycle
// while the receiver is ready, the eighth marked last and, on the final step,
// done. A step beat with no circle in progress is taken and produces nothing.
// Each point of a step goes from the snapshot register through the point
// generator into the single output register, which the step holds for its
// eight points; the next beat is taken in the same cycle as the eighth point
// of the current step enters the output register.
// When the receiver stalls, the output register holds its point and the
// point sequencer waits; input is refused once a step is waiting to emit.
// Reset clears the circle state, empties the output and sets the fold offset
// register (APB address 0) to 180.
module circle_octant_rasterizer import cor_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     mode_i,
  input  logic signed [CoordW-1:0] center_x_i,
  input  logic signed [CoordW-1:0] center_y_i,
  input  logic        [RadW-1:0]   radius_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [PointW-1:0] point_x_o,
  output logic signed [PointW-1:0] point_y_o,
  output logic                     last_of_step_o,
  output logic                     circle_done_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic        [AddrW-1:0]  paddr,
  input  logic        [DataW-1:0]  pwdata,
  output logic        [DataW-1:0]  prdata,
  output logic                     pready
);

  logic        [OffW-1:0]   fold_q;
  logic        [StepW-1:0]  step_x_q, step_x_d;
  logic signed [StepW-1:0]  step_y_q, step_y_d;
  logic signed [DecW-1:0]   dec_q, dec_d;
  logic signed [CoordW-1:0] cx_q, cy_q;
  logic                     active_q, active_d;
  step_snap_t               snap_q, snap_d;
  logic                     busy_q, busy_d;
  logic        [IdxW-1:0]   idx_q, idx_d;
  logic                     out_valid_q;
  logic signed [PointW-1:0] px_q, py_q;
  logic                     last_q, done_q;

  logic                     in_fire, out_load, step_go;
  logic signed [StepW:0]    x_cmp, y_cmp, nx_cmp, ny_cmp;
  logic signed [DecW+1:0]   dec_ext, dec_sum;
  logic signed [PointW-1:0] gen_x, gen_y;

  assign pready = 1'b1;
  assign prdata = (paddr[AddrW-1] == RegFoldOff) ? {{(DataW-OffW){1'b0}}, fold_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= FoldOffRst;
    end else if (psel && penable && pwrite && (paddr[AddrW-1] == RegFoldOff)) begin
      fold_q <= pwdata[OffW-1:0];
    end
  end

  assign out_load   = busy_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy_q || (out_load && (idx_q == LastIdx));
  assign in_fire    = in_valid_i && in_ready_o;

  assign x_cmp   = $signed({1'b0, step_x_q});
  assign y_cmp   = {step_y_q[StepW-1], step_y_q};
  assign step_go = in_fire && (mode_i != ModeStart) && active_q && !(x_cmp > y_cmp);
  assign dec_ext = {{2{dec_q[DecW-1]}}, dec_q};

  always_comb begin
    step_x_d = step_x_q;
    step_y_d = step_y_q;
    dec_d    = dec_q;
    active_d = active_q;
    dec_sum  = '0;
    nx_cmp   = x_cmp;
    ny_cmp   = y_cmp;
    snap_d   = snap_q;
    if (in_fire && (mode_i == ModeStart)) begin
      step_x_d = '0;
      step_y_d = $signed({1'b0, radius_i});
      dec_d    = $signed(17'sd3 - $signed({{(DecW-RadW-1){1'b0}}, radius_i, 1'b0}));
      active_d = 1'b1;
    end else if (step_go) begin
      if (dec_q[DecW-1]) begin
        dec_sum = dec_ext + $signed({x_cmp[StepW], x_cmp, 2'b00}) + 19'sd6;
      end else begin
        dec_sum  = dec_ext + $signed({x_cmp - y_cmp, 2'b00}) + 19'sd10;
        step_y_d = step_y_q - 13'sd1;
      end
      dec_d    = dec_sum[DecW-1:0];
      step_x_d = step_x_q + 13'd1;
      nx_cmp   = $signed({1'b0, step_x_d});
      ny_cmp   = {step_y_d[StepW-1], step_y_d};
      active_d = !(nx_cmp > ny_cmp);
      snap_d.h    = cx_q;
      snap_d.k    = cy_q;
      snap_d.x    = step_x_q;
      snap_d.y    = step_y_q;
      snap_d.done = nx_cmp > ny_cmp;
    end
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (out_load) begin
      idx_d = idx_q + 3'd1;
      if (idx_q == LastIdx) begin
        busy_d = 1'b0;
      end
    end
    if (step_go) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q <= '0;
      step_y_q <= '0;
      dec_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      active_q <= 1'b0;
      busy_q   <= 1'b0;
      idx_q    <= '0;
    end else begin
      step_x_q <= step_x_d;
      step_y_q <= step_y_d;
      dec_q    <= dec_d;
      active_q <= active_d;
      busy_q   <= busy_d;
      idx_q    <= idx_d;
      if (in_fire && (mode_i == ModeStart)) begin
        cx_q <= center_x_i;
        cy_q <= center_y_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  cor_point_gen u_point_gen (
    .snap_i    (snap_q),
    .idx_i     (idx_q),
    .offset_i  (fold_q),
    .point_x_o (gen_x),
    .point_y_o (gen_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      px_q   <= gen_x;
      py_q   <= gen_y;
      last_q <= idx_q == LastIdx;
      done_q <= (idx_q == LastIdx) && snap_q.done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign point_x_o      = px_q;
  assign point_y_o      = py_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the circle octant rasterizer: point prediction and checking.
`timescale 1ns / 1ps

module testbench;
  import cor_pkg::*;

  localparam logic ModeStep = ~ModeStart;
  localparam logic [AddrW-1:0] FoldAddr = AddrW'(4 * RegFoldOff);
  localparam logic [AddrW-1:0] SpareAddr = AddrW'(4);
  localparam int MaxCycles = 100_000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic signed [PointW-1:0] x;
    logic signed [PointW-1:0] y;
    logic last;
    logic done;
  } pixel_t;

  class circle_point_board;
    logic [OffW-1:0] fold;
    logic signed [StepW:0] col;
    logic signed [StepW-1:0] row;
    logic signed [DecW-1:0] dec;
    logic signed [CoordW-1:0] org_x;
    logic signed [CoordW-1:0] org_y;
    bit open;
    pixel_t pending_points[$];
    int errors;
    int checked;

    function new();
      fold = FoldOffRst;
      col = '0;
      row = '0;
      dec = '0;
      org_x = '0;
      org_y = '0;
      open = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function void add_point(int px, int py, logic last, logic done);
      pixel_t p;
      p.x = PointW'(px);
      p.y = PointW'(py);
      p.last = last;
      p.done = done;
      pending_points.push_back(p);
    endfunction

    // Returns the number of points that the accepted beat produces.
    function int rasterize_step(logic mode, logic signed [CoordW-1:0] cx,
                                logic signed [CoordW-1:0] cy, logic [RadW-1:0] r);
      int h;
      int k;
      int x;
      int y;
      int o;
      logic done;
      if (mode == ModeStart) begin
        org_x = cx;
        org_y = cy;
        col = '0;
        row = $signed({1'b0, r});
        dec = DecW'(3 - 2 * int'(r));
        open = 1'b1;
        return 0;
      end
      if (!open || col > row) return 0;
      h = org_x;
      k = org_y;
      x = col;
      y = row;
      o = int'(fold);
      if (dec < 0) begin
        dec = DecW'(int'(dec) + 4 * x + 6);
      end else begin
        dec = DecW'(int'(dec) + 4 * (x - y) + 10);
        row = row - 1'b1;
      end
      col = col + 1'b1;
      done = (col > row);
      if (done) open = 1'b0;
      add_point(h + x, k + y - o, 1'b0, 1'b0);
      add_point(h - x + o, k + y - o, 1'b0, 1'b0);
      add_point(h + x, k - y, 1'b0, 1'b0);
      add_point(h - x + o, k - y, 1'b0, 1'b0);
      add_point(h + y, k + x - o, 1'b0, 1'b0);
      add_point(h - y + o, k + x - o, 1'b0, 1'b0);
      add_point(h + y, k - x, 1'b0, 1'b0);
      add_point(h - y + o, k - x, 1'b1, done);
      return 8;
    endfunction

    function void check_point(pixel_t got);
      pixel_t want;
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected point expected none actual (%0d, %0d, last %0b, done %0b)",
                 $time, got.x, got.y, got.last, got.done);
        return;
      end
      want = pending_points.pop_front();
      checked++;
      if (got.x !== want.x || got.y !== want.y || got.last !== want.last ||
          got.done !== want.done) begin
        errors++;
        $display("%0t: point mismatch expected (%0d, %0d, last %0b, done %0b) %s",
                 $time, want.x, want.y, want.last, want.done,
                 $sformatf("actual (%0d, %0d, last %0b, done %0b)",
                           got.x, got.y, got.last, got.done));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic mode_i = ModeStart;
  logic signed [CoordW-1:0] center_x_i = '0;
  logic signed [CoordW-1:0] center_y_i = '0;
  logic [RadW-1:0] radius_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [PointW-1:0] point_x_o;
  logic signed [PointW-1:0] point_y_o;
  logic last_of_step_o;
  logic circle_done_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  circle_point_board sb = new();
  int beats = 0;
  int useful_beats = 0;
  int burst_left = 0;
  int fold_writes = 0;
  int hold_ask = 0;
  int cycle_count = 0;
  bit gaps_on = 1'b1;
  bit rx_calm = 1'b0;

  circle_octant_rasterizer u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .mode_i(mode_i),
    .center_x_i(center_x_i),
    .center_y_i(center_y_i),
    .radius_i(radius_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .point_x_o(point_x_o),
    .point_y_o(point_y_o),
    .last_of_step_o(last_of_step_o),
    .circle_done_o(circle_done_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MaxCycles) begin
      $display("circle_octant_rasterizer verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_point({point_x_o, point_y_o, last_of_step_o, circle_done_o});
    end
  end

  // The receiver alternates ready runs and stalls, or stays ready when calm, and on request holds off a long stretch.
  initial begin
    int hold_seen;
    hold_seen = 0;
    @(posedge clk_i);
    forever begin
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        repeat (HoldCycles) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
      end else if (rx_calm) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 10)) begin
          out_ready_i <= 1'b1;
          @(posedge clk_i);
        end
        repeat ($urandom_range(1, 5)) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_beat(input logic mode, input logic signed [CoordW-1:0] cx,
                           input logic signed [CoordW-1:0] cy, input logic [RadW-1:0] r);
    int made;
    in_valid_i <= 1'b1;
    mode_i <= mode;
    center_x_i <= cx;
    center_y_i <= cy;
    radius_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    made = sb.rasterize_step(mode, cx, cy, r);
    beats++;
    if (mode == ModeStart || made > 0) useful_beats++;
  endtask

  task automatic paced_beat(input logic mode, input logic signed [CoordW-1:0] cx,
                            input logic signed [CoordW-1:0] cy, input logic [RadW-1:0] r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        repeat ($urandom_range(1, 8)) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
        end
      end
    end
    burst_left--;
    send_beat(mode, cx, cy, r);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending_points.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [AddrW-1:0] addr,
                          input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_fold(input logic [OffW-1:0] value);
    logic [DataW-1:0] rd;
    apb_xfer(1'b1, FoldAddr, DataW'(value), rd);
    apb_xfer(1'b1, SpareAddr, DataW'($urandom_range(0, 4095)), rd);
    apb_xfer(1'b0, FoldAddr, '0, rd);
    if (rd !== DataW'(value)) begin
      sb.errors++;
      $display("%0t: fold offset readback expected %0d actual %0d", $time, value, rd);
    end
    sb.fold = value;
    fold_writes++;
  endtask

  initial begin
    int target;
    int sel;
    int pick;
    int limit;
    int n;
    logic [OffW-1:0] offset;
    logic [RadW-1:0] r;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(ModeStep, CoordW'(5), CoordW'(-5), RadW'(7));
    send_beat(ModeStart, CoordW'(0), CoordW'(0), RadW'(0));
    send_beat(ModeStep, CoordW'(0), CoordW'(0), RadW'(0));
    send_beat(ModeStep, CoordW'(-1), CoordW'(-1), RadW'(4095));
    send_beat(ModeStart, CoordW'(-8192), CoordW'(-8192), RadW'(4095));
    send_beat(ModeStep, CoordW'(8191), CoordW'(8191), RadW'(0));
    send_beat(ModeStep, CoordW'(0), CoordW'(0), RadW'(0));
    send_beat(ModeStart, CoordW'(8191), CoordW'(8191), RadW'(4095));
    send_beat(ModeStep, CoordW'(0), CoordW'(0), RadW'(0));
    send_beat(ModeStart, CoordW'(8191), CoordW'(-8192), RadW'(1));
    send_beat(ModeStep, CoordW'(0), CoordW'(0), RadW'(0));
    send_beat(ModeStep, CoordW'(0), CoordW'(0), RadW'(0));
    send_beat(ModeStart, CoordW'(-8192), CoordW'(8191), RadW'(5));
    while (sb.open) send_beat(ModeStep, CoordW'(0), CoordW'(0), RadW'(0));
    send_beat(ModeStep, CoordW'(0), CoordW'(0), RadW'(0));
    send_beat(ModeStart, CoordW'(-1), CoordW'(0), RadW'(2048));
    send_beat(ModeStep, CoordW'(0), CoordW'(0), RadW'(0));
    send_beat(ModeStep, CoordW'(0), CoordW'(0), RadW'(0));
    wait_idle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: offset = '0;
        1: offset = '1;
        3: offset = OffW'(1);
        default: offset = OffW'($urandom_range(0, 4095));
      endcase
      set_fold(offset);
      gaps_on = (phase != 2);
      rx_calm = (phase == 3);
      target = useful_beats + 64;
      while (useful_beats < target) begin
        if (phase == 1 && hold_ask == 0 && useful_beats > target - 50) hold_ask++;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          pick = $urandom_range(0, 99);
          if (pick < 75) r = RadW'($urandom_range(0, 24));
          else if (pick < 90) r = RadW'($urandom_range(25, 400));
          else if (pick < 96) r = RadW'($urandom);
          else r = '1;
          limit = $urandom_range(1, 40);
          paced_beat(ModeStart, CoordW'($urandom), CoordW'($urandom), r);
          n = 0;
          while (sb.open && n < limit) begin
            paced_beat(ModeStep, CoordW'($urandom), CoordW'($urandom), RadW'($urandom));
            n++;
          end
          if ($urandom_range(0, 2) == 0) begin
            paced_beat(ModeStep, CoordW'($urandom), CoordW'($urandom), RadW'($urandom));
          end
        end else if (sel < 85) begin
          paced_beat(ModeStep, CoordW'($urandom), CoordW'($urandom), RadW'($urandom));
        end else begin
          paced_beat(ModeStart, CoordW'($urandom), CoordW'($urandom), RadW'($urandom));
        end
      end
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    $display("Covered %0d input beats (%0d starts or drawing steps) and %0d checked points,",
             beats, useful_beats, sb.checked);
    $display("under %0d fold offset writes, with sender gaps, output stalls and one long hold.",
             fold_writes);
    if (sb.errors == 0) begin
      $display("circle_octant_rasterizer verification clean");
    end else begin
      $display("circle_octant_rasterizer verification failed");
    end
    $finish;
  end

endmodule
